FILE: rtl/rfb_pkg.sv
package rfb_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_DRAW  = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_WRITTEN = 2'd0;
   localparam logic [1:0] STATUS_CLIPPED = 2'd1;
   localparam logic [1:0] STATUS_CLEARED = 2'd2;
   localparam logic [1:0] STATUS_READ    = 2'd3;

   // Rotation settings in quarter turns.
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [1:0] ROTATION_RESET = ROT_90;

   // Register index of the rotation register on the APB port.
   localparam logic [2:0] CSR_IDX_ROTATION = 3'd0;

   localparam logic [7:0] FILL_BYTE = 8'hFF;

   // Depths of the command queue and of the result queue.
   localparam int CMD_DEPTH  = 4;
   localparam int RES_DEPTH  = 4;
   localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);
   localparam int RES_DATA_W = 10;

   // Kind of work the back end has to carry out for one item.
   typedef enum logic [1:0] {
      OP_DRAW,
      OP_CLIP,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] color;
      logic [1:0] slot;
   } cmd_type;

endpackage

FILE: rtl/rfb_queue.sv
module rfb_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [DATA_W-1:0]                push_data,
   input  logic                             pop,
   output logic [DATA_W-1:0]                pop_data,
   output logic                             empty,
   output logic                             full,
   output logic [$clog2(DEPTH + 1)-1:0]     count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slots_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/rfb_front.sv
module rfb_front #(
   parameter int PANEL_WIDTH  = 180,
   parameter int PANEL_HEIGHT = 100,
   parameter int LINE_BYTES   = 45,
   parameter int ROW_OFFSET   = 3,
   parameter int IDX_W        = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          req_func,
   input  logic signed [15:0]  req_pixel_x,
   input  logic signed [15:0]  req_pixel_y,
   input  logic [1:0]          req_pixel_color,
   input  logic [12:0]         req_read_index,
   input  logic [1:0]          rotation,
   input  logic                busy,
   input  logic                q_full,
   output logic                q_push,
   output rfb_pkg::cmd_type    q_cmd,
   output logic [IDX_W-1:0]    q_addr
);

   localparam int XW     = $clog2(PANEL_WIDTH);
   localparam int YW_RAW = $clog2(PANEL_HEIGHT + ROW_OFFSET);
   localparam int YW     = (YW_RAW < 1) ? 1 : YW_RAW;

   localparam logic [15:0] W_C    = 16'(PANEL_WIDTH);
   localparam logic [15:0] H_C    = 16'(PANEL_HEIGHT);
   localparam logic [15:0] W_LAST = 16'(PANEL_WIDTH - 1);
   localparam logic [15:0] H_LAST = 16'(PANEL_HEIGHT - 1);
   localparam logic [15:0] OFS_C  = 16'(ROW_OFFSET);
   localparam logic [IDX_W-1:0] LB_C = IDX_W'(LINE_BYTES);

   logic                  f1_valid_ff, f1_valid_in;
   rfb_pkg::op_type       f1_op_ff, f1_op_in;
   logic [1:0]            f1_color_ff;
   logic [XW-1:0]         f1_px_ff, f1_px_in;
   logic [YW-1:0]         f1_py_ff, f1_py_in;
   logic [12:0]           f1_index_ff;

   logic                  accept;
   logic                  clipped;
   logic [15:0]           x_mag, y_mag;
   logic [15:0]           lw, lh;
   logic [15:0]           px, py;

   assign full   = busy || (f1_valid_ff && q_full);
   assign accept = push && !full;

   // Clip against the logical area, then map the point to the panel.
   always_comb begin
      x_mag   = $unsigned(req_pixel_x);
      y_mag   = $unsigned(req_pixel_y);
      lw      = rotation[0] ? H_C : W_C;
      lh      = rotation[0] ? W_C : H_C;
      clipped = req_pixel_x[15] || req_pixel_y[15] || (x_mag >= lw) || (y_mag >= lh);
      case (rotation)
         rfb_pkg::ROT_90: begin
            px = W_LAST - y_mag;
            py = x_mag;
         end
         rfb_pkg::ROT_180: begin
            px = W_LAST - x_mag;
            py = H_LAST - y_mag;
         end
         rfb_pkg::ROT_270: begin
            px = y_mag;
            py = H_LAST - x_mag;
         end
         default: begin
            px = x_mag;
            py = y_mag;
         end
      endcase
      f1_px_in = XW'(px);
      f1_py_in = YW'(py + OFS_C);
      unique case (req_func)
         rfb_pkg::FUNC_DRAW:  f1_op_in = clipped ? rfb_pkg::OP_CLIP : rfb_pkg::OP_DRAW;
         rfb_pkg::FUNC_CLEAR: f1_op_in = rfb_pkg::OP_CLEAR;
         default:             f1_op_in = rfb_pkg::OP_READ;
      endcase
      f1_valid_in = accept || (f1_valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_op_ff    <= f1_op_in;
         f1_color_ff <= req_pixel_color;
         f1_px_ff    <= f1_px_in;
         f1_py_ff    <= f1_py_in;
         f1_index_ff <= req_read_index;
      end
   end

   // Byte address: one row multiply and add, or the read index as given.
   assign q_push      = f1_valid_ff && !q_full;
   assign q_cmd.op    = f1_op_ff;
   assign q_cmd.color = f1_color_ff;
   assign q_cmd.slot  = f1_px_ff[1:0];
   assign q_addr = (f1_op_ff == rfb_pkg::OP_READ) ? IDX_W'(f1_index_ff)
                 : IDX_W'(f1_px_ff >> 2) + IDX_W'(f1_py_ff) * LB_C;

endmodule

FILE: rtl/rfb_back.sv
module rfb_back #(
   parameter int STORE_BYTES = 4635,
   parameter int IDX_W       = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  rfb_pkg::cmd_type                q_cmd,
   input  logic [IDX_W-1:0]                q_addr,
   output logic                            q_pop,
   input  logic [rfb_pkg::RES_CNT_W-1:0]   res_count,
   output logic                            res_push,
   output logic [1:0]                      res_status,
   output logic [7:0]                      res_data,
   output logic                            busy
);

   localparam int ADDR_RAW = $clog2(STORE_BYTES);
   localparam int ADDR_W   = (ADDR_RAW < 1) ? 1 : ADDR_RAW;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_BYTES - 1);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_RUN,
      ST_CLEAR
   } state_type;

   logic [7:0]        frame_store_ff [STORE_BYTES];
   logic [7:0]        rd_data_ff;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              b1_valid_ff;
   rfb_pkg::cmd_type  b1_cmd_ff;
   logic [ADDR_W-1:0] b1_addr_ff;
   logic              b1_hit_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   logic              issue;
   logic              in_range;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]        mem_wd;
   logic [7:0]        base;

   function automatic logic [7:0] merge_pixel(input logic [7:0] old,
                                              input logic [1:0] slot,
                                              input logic [1:0] color);
      logic [7:0] res;
      case (slot)
         2'd0:    res = (old & 8'h3F) | {color, 6'b0};
         2'd1:    res = (old & 8'hCF) | {2'b0, color, 4'b0};
         2'd2:    res = (old & 8'hF3) | {4'b0, color, 2'b0};
         default: res = (old & 8'hFC) | {6'b0, color};
      endcase
      return res;
   endfunction

   assign busy     = (state_ff == ST_INIT);
   assign in_range = (32'(q_addr) < STORE_BYTES);
   assign issue    = (state_ff == ST_RUN) && !q_empty
                  && !(b1_valid_ff && (b1_cmd_ff.op == rfb_pkg::OP_CLEAR))
                  && ((32'(res_count) + 32'(b1_valid_ff)) < rfb_pkg::RES_DEPTH);
   assign q_pop    = issue;

   // The read issued at the last edge misses the write made at that same edge.
   assign base = (fwd_valid_ff && (fwd_addr_ff == b1_addr_ff)) ? fwd_data_ff : rd_data_ff;

   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      mem_we     = 1'b0;
      mem_wa     = b1_addr_ff;
      mem_wd     = merge_pixel(base, b1_cmd_ff.slot, b1_cmd_ff.color);
      res_push   = 1'b0;
      res_status = rfb_pkg::STATUS_WRITTEN;
      res_data   = 8'h00;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = rfb_pkg::FILL_BYTE;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_LAST) begin
               state_in = ST_RUN;
               sweep_in = '0;
               if (state_ff == ST_CLEAR) begin
                  res_push   = 1'b1;
                  res_status = rfb_pkg::STATUS_CLEARED;
               end
            end
         end
         default: begin
            if (b1_valid_ff) begin
               unique case (b1_cmd_ff.op)
                  rfb_pkg::OP_DRAW: begin
                     mem_we   = b1_hit_ff;
                     res_push = 1'b1;
                  end
                  rfb_pkg::OP_CLIP: begin
                     res_push   = 1'b1;
                     res_status = rfb_pkg::STATUS_CLIPPED;
                  end
                  rfb_pkg::OP_CLEAR: begin
                     state_in = ST_CLEAR;
                     sweep_in = '0;
                  end
                  default: begin
                     res_push   = 1'b1;
                     res_status = rfb_pkg::STATUS_READ;
                     res_data   = b1_hit_ff ? base : 8'h00;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         b1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         b1_valid_ff  <= issue;
         fwd_valid_ff <= mem_we;
      end
      if (issue) begin
         b1_cmd_ff  <= q_cmd;
         b1_addr_ff <= q_addr[ADDR_W-1:0];
         b1_hit_ff  <= in_range;
      end
      fwd_addr_ff <= mem_wa;
      fwd_data_ff <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_ff[mem_wa] <= mem_wd;
      end
      if (issue) begin
         rd_data_ff <= frame_store_ff[q_addr[ADDR_W-1:0]];
      end
   end

endmodule

FILE: rtl/rotated_2bpp_frame_buffer.sv
// Frame store of 2-bit grayscale pixels, four to a byte, first pixel in the
// top bits. Requests enter through a queue-like port: an item is taken at a
// clock edge where push is high and full is low. Each item yields exactly one
// result, shown on the rsp ports while empty is low and taken when pop is high.
// A draw item clips the signed point against the logical area, rotates it,
// moves it down by ROW_OFFSET rows and merges the color into its byte. A clear
// item fills the store with 0xFF; a read item returns one byte.
// The front end registers each item and forms its byte address; a four-deep
// command queue feeds the back end, which does the read-modify-write on the
// store. Draws and reads sustain one item per clock while results are popped;
// a result passes the front-end register, the command queue, the back-end
// stage and the result queue. A clear sweeps all STORE_BYTES bytes (4635 by
// default) to 0xFF before its result appears. After reset the store is swept
// to 0xFF, full staying high; each item takes the rotation set when it enters.
// When the receiver stops popping, the four-deep result queue fills, the back
// end stops issuing, and full rises once the command queue is full too.
// The rotation register sits at APB address 0 and resets to one quarter turn.
module rotated_2bpp_frame_buffer #(
   parameter int PANEL_WIDTH  = 180,
   parameter int PANEL_HEIGHT = 100,
   parameter int LINE_BYTES   = 45,
   parameter int ROW_OFFSET   = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_pixel_x,
   input  logic signed [15:0] req_pixel_y,
   input  logic [1:0]         req_pixel_color,
   input  logic [12:0]        req_read_index,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_read_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int STORE_BYTES = LINE_BYTES * (PANEL_HEIGHT + ROW_OFFSET);
   // Widest byte address a mapped point can produce.
   localparam int ADDR_MAX  = (PANEL_WIDTH - 1) / 4 + (PANEL_HEIGHT - 1 + ROW_OFFSET) * LINE_BYTES;
   localparam int CALC_W    = $clog2(ADDR_MAX + 1);
   localparam int STORE_W   = $clog2(STORE_BYTES);
   localparam int IDX_A     = (CALC_W > 13) ? CALC_W : 13;
   localparam int IDX_W     = (STORE_W > IDX_A) ? STORE_W : IDX_A;
   localparam int CMD_W     = $bits(rfb_pkg::cmd_type) + IDX_W;

   logic [1:0]                     rotation_ff;
   logic                           csr_write;
   logic                           csr_hit;

   logic                           busy;
   logic                           cq_push, cq_pop, cq_empty, cq_full;
   rfb_pkg::cmd_type               f_cmd, b_cmd;
   logic [IDX_W-1:0]               f_addr, b_addr;
   logic [CMD_W-1:0]               cq_out;

   logic                           res_push;
   logic [1:0]                     res_status;
   logic [7:0]                     res_data;
   logic [rfb_pkg::RES_CNT_W-1:0]  res_count;
   logic [rfb_pkg::RES_DATA_W-1:0] res_out;

   // Configuration: only the rotation register exists.
   assign pready    = 1'b1;
   assign csr_hit   = ((paddr >> 2) == rfb_pkg::CSR_IDX_ROTATION);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? {30'b0, rotation_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= rfb_pkg::ROTATION_RESET;
      end else if (csr_write) begin
         rotation_ff <= pwdata[1:0];
      end
   end

   rfb_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .LINE_BYTES   (LINE_BYTES),
      .ROW_OFFSET   (ROW_OFFSET),
      .IDX_W        (IDX_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_func        (req_func),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_color (req_pixel_color),
      .req_read_index  (req_read_index),
      .rotation        (rotation_ff),
      .busy            (busy),
      .q_full          (cq_full),
      .q_push          (cq_push),
      .q_cmd           (f_cmd),
      .q_addr          (f_addr)
   );

   // Command queue between the front end and the store side.
   rfb_queue #(
      .DATA_W (CMD_W),
      .DEPTH  (rfb_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data ({f_cmd, f_addr}),
      .pop       (cq_pop),
      .pop_data  (cq_out),
      .empty     (cq_empty),
      .full      (cq_full),
      .count     ()
   );

   assign b_cmd  = cq_out[CMD_W-1:IDX_W];
   assign b_addr = cq_out[IDX_W-1:0];

   rfb_back #(
      .STORE_BYTES (STORE_BYTES),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (cq_empty),
      .q_cmd      (b_cmd),
      .q_addr     (b_addr),
      .q_pop      (cq_pop),
      .res_count  (res_count),
      .res_push   (res_push),
      .res_status (res_status),
      .res_data   (res_data),
      .busy       (busy)
   );

   // Result queue; the back end only issues an item when a slot is reserved.
   rfb_queue #(
      .DATA_W (rfb_pkg::RES_DATA_W),
      .DEPTH  (rfb_pkg::RES_DEPTH)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data ({res_status, res_data}),
      .pop       (pop),
      .pop_data  (res_out),
      .empty     (empty),
      .full      (),
      .count     (res_count)
   );

   assign rsp_status    = res_out[9:8];
   assign rsp_read_data = res_out[7:0];

endmodule
